### rtl/segment_segment_closest_points_2d_assert.svh
// Assertion macros for the segment closest-points block.
`ifndef SEGMENT_SEGMENT_CLOSEST_POINTS_2D_ASSERT_SVH
`define SEGMENT_SEGMENT_CLOSEST_POINTS_2D_ASSERT_SVH
`ifndef SYNTHESIS
`define SSC_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`define SSC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define SSC_ASSERT_IMPL(lbl, pre, post, msg)
`define SSC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/ssc_pkg.sv
// Package: shared widths and constants of the segment closest-points block.
`default_nettype none
package ssc_pkg;
	localparam int COORD_WIDTH = 24;
	localparam int PARAM_FRACTION_BITS = 16;
	localparam int THR_WIDTH = 24;
	localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(5790);
	localparam int GAP_WIDTH = 49;
endpackage
`default_nettype wire

### rtl/ssc_if.sv
// Interfaces: segment pair input channel and closest-points result channel.
`default_nettype none
interface ssc_seg_if #(parameter int CW = ssc_pkg::COORD_WIDTH);
	logic valid;
	logic ready;
	logic signed [CW-1:0] a_start_x;
	logic signed [CW-1:0] a_start_y;
	logic signed [CW-1:0] a_end_x;
	logic signed [CW-1:0] a_end_y;
	logic signed [CW-1:0] b_start_x;
	logic signed [CW-1:0] b_start_y;
	logic signed [CW-1:0] b_end_x;
	logic signed [CW-1:0] b_end_y;
	modport source(output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, input ready);
	modport sink(input valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface ssc_res_if #(parameter int CW = ssc_pkg::COORD_WIDTH);
	logic valid;
	logic ready;
	logic signed [CW-1:0] near_a_x;
	logic signed [CW-1:0] near_a_y;
	logic signed [CW-1:0] near_b_x;
	logic signed [CW-1:0] near_b_y;
	logic [ssc_pkg::GAP_WIDTH-1:0] gap_squared;
	modport source(output valid, near_a_x, near_a_y, near_b_x, near_b_y, gap_squared,
		input ready);
	modport sink(input valid, near_a_x, near_a_y, near_b_x, near_b_y, gap_squared,
		output ready);
endinterface
`default_nettype wire

### rtl/segment_segment_closest_points_2d.sv
// Top level: closest points between two 2D segments, fully pipelined.
// Usage:
//   seg carries one segment pair per beat (A start/end, B start/end, Q11.12).
//   res returns one beat per input: the nearest point on A and on B and the
//   squared gap between them (Q.24, saturating).
//   cfg_we/cfg_wdata write the degenerate-length threshold; write it while idle.
// Throughput: one beat per cycle while res accepts. Two clamped dividers lie in
//   series, each PF + 4 stages, one quotient bit per stage: the first gives A's
//   parameter, the second the projection onto B that depends on the point formed
//   from it.
// The whole pipeline advances together; while res is stalled with a beat
//   waiting, seg.ready is low and every stage holds. Nothing is lost or repeated.
// Reset clears all valid bits and loads the threshold with its default.
`default_nettype none
module segment_segment_closest_points_2d #(
	parameter int COORD_WIDTH         = ssc_pkg::COORD_WIDTH,
	parameter int PARAM_FRACTION_BITS = ssc_pkg::PARAM_FRACTION_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	ssc_seg_if.sink                            seg,
	ssc_res_if.source                          res,
	input  wire logic                          cfg_we,
	input  wire logic [ssc_pkg::THR_WIDTH-1:0] cfg_wdata
);
	localparam int CW  = COORD_WIDTH;
	localparam int PF  = PARAM_FRACTION_BITS;
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * DW;
	localparam int SW  = PW + 1;
	localparam int TW  = DW + 1;
	localparam int NPW = DW + TW;
	localparam int NW  = NPW + 1;
	localparam int QW  = PF + 1;
	localparam int LD  = PF + 4;
	localparam int UW  = DW + 1;
	localparam int QSW = 2 * UW + 1;
	localparam int GW  = ssc_pkg::GAP_WIDTH;
	localparam int XW  = (QSW > GW) ? QSW : GW + 1;
	localparam int STG_P   = 3 + LD;
	localparam int STG_X   = STG_P + 5 + LD;
	localparam int STG_OUT = STG_X + 6;
	localparam logic [QW-1:0] ONE = {1'b1, {PF{1'b0}}};
	localparam logic [GW-1:0] GMAX = '1;

	logic en;
	logic [STG_OUT:1] vld_q;
	logic [ssc_pkg::THR_WIDTH-1:0] thr_q;

	// stage 1: differences
	logic signed [DW-1:0] dax_s1, day_s1, dbx_s1, dby_s1, rx_s1, ry_s1;
	logic signed [DW-1:0] wsx_s1, wsy_s1, wex_s1, wey_s1;
	logic signed [CW-1:0] asx_s1, asy_s1, aex_s1, aey_s1, bsx_s1, bsy_s1;
	// stage 2: products
	logic signed [PW-1:0] aa1_s2, aa2_s2, ee1_s2, ee2_s2, c1_s2, c2_s2, k1_s2, k2_s2;
	logic signed [PW-1:0] m1_s2, m2_s2, s1_s2, s2_s2, t1_s2, t2_s2;
	logic signed [DW-1:0] dax_s2, day_s2, dbx_s2, dby_s2;
	logic signed [CW-1:0] asx_s2, asy_s2, aex_s2, aey_s2, bsx_s2, bsy_s2;
	// stage 3: sums
	logic signed [SW-1:0] a_s3, e_s3, cr_s3, cbr_s3, dbr_s3, nas_s3, nae_s3;
	logic signed [DW-1:0] dax_s3, day_s3, dbx_s3, dby_s3;
	logic signed [CW-1:0] asx_s3, asy_s3, aex_s3, aey_s3, bsx_s3, bsy_s3;
	logic pa, pe;

	logic [QW-1:0] sa0, qs, qe, sbd, sbn;

	// taps of the side payload
	logic signed [CW-1:0] aex_p, aey_p;
	logic signed [DW-1:0] dax_p, day_p;
	logic signed [CW-1:0] bsx_p2, bsy_p2;
	logic signed [DW-1:0] dbx_p3, dby_p3;
	logic signed [SW-1:0] e_p5;
	logic signed [DW-1:0] dax_x, day_x, dbx_x, dby_x;
	logic signed [CW-1:0] aex_x, aey_x, bsx_x, bsy_x;
	logic pa_x, pe_x;
	logic signed [CW-1:0] asx_x2, asy_x2, bsx_x2, bsy_x2;
	logic bp_x2;
	logic [QW-1:0] sa0_x, qs_x, qe_x, sbd_x;
	logic nneg_x, ngt_x;

	// projection of the first point onto B
	logic signed [DW-1:0] pax0, pay0;
	logic signed [TW-1:0] tx_s7, ty_s7;
	logic signed [NPW-1:0] np1_s8, np2_s8;
	logic signed [NW-1:0] n_s9;

	// final point forming and gap
	logic [QW-1:0] sa_x, sb_x;
	logic signed [DW-1:0] pax_l, pay_l, pbx_l, pby_l;
	logic signed [DW-1:0] pax_m, pay_m, pbx_m, pby_m;
	logic signed [DW-1:0] pax_s13, pay_s13, pbx_s13, pby_s13;
	logic signed [UW-1:0] dx_s13, dy_s13;
	logic signed [DW-1:0] pax_s14, pay_s14, pbx_s14, pby_s14;
	logic [UW-1:0] ux_s14, uy_s14;
	logic signed [DW-1:0] pax_s15, pay_s15, pbx_s15, pby_s15;
	logic [2*UW-1:0] sqx_s15, sqy_s15;
	logic [XW-1:0] gsum;
	logic signed [DW-1:0] pax_s16, pay_s16, pbx_s16, pby_s16;
	logic [GW-1:0] gap_s16;

	assign en = !vld_q[STG_OUT] || res.ready;
	assign seg.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			thr_q <= ssc_pkg::THR_RESET;
		end else begin
			if (en) begin
				vld_q <= {vld_q[STG_OUT-1:1], seg.valid};
			end
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dax_s1 <= DW'(seg.a_start_x) - DW'(seg.a_end_x);
			day_s1 <= DW'(seg.a_start_y) - DW'(seg.a_end_y);
			dbx_s1 <= DW'(seg.b_end_x) - DW'(seg.b_start_x);
			dby_s1 <= DW'(seg.b_end_y) - DW'(seg.b_start_y);
			rx_s1  <= DW'(seg.a_end_x) - DW'(seg.b_start_x);
			ry_s1  <= DW'(seg.a_end_y) - DW'(seg.b_start_y);
			wsx_s1 <= DW'(seg.b_start_x) - DW'(seg.a_end_x);
			wsy_s1 <= DW'(seg.b_start_y) - DW'(seg.a_end_y);
			wex_s1 <= DW'(seg.b_end_x) - DW'(seg.a_end_x);
			wey_s1 <= DW'(seg.b_end_y) - DW'(seg.a_end_y);
			asx_s1 <= seg.a_start_x;
			asy_s1 <= seg.a_start_y;
			aex_s1 <= seg.a_end_x;
			aey_s1 <= seg.a_end_y;
			bsx_s1 <= seg.b_start_x;
			bsy_s1 <= seg.b_start_y;

			aa1_s2 <= PW'(dax_s1) * PW'(dax_s1);
			aa2_s2 <= PW'(day_s1) * PW'(day_s1);
			ee1_s2 <= PW'(dbx_s1) * PW'(dbx_s1);
			ee2_s2 <= PW'(dby_s1) * PW'(dby_s1);
			c1_s2  <= PW'(dax_s1) * PW'(dby_s1);
			c2_s2  <= PW'(day_s1) * PW'(dbx_s1);
			k1_s2  <= PW'(dbx_s1) * PW'(ry_s1);
			k2_s2  <= PW'(dby_s1) * PW'(rx_s1);
			m1_s2  <= PW'(dbx_s1) * PW'(rx_s1);
			m2_s2  <= PW'(dby_s1) * PW'(ry_s1);
			s1_s2  <= PW'(dax_s1) * PW'(wsx_s1);
			s2_s2  <= PW'(day_s1) * PW'(wsy_s1);
			t1_s2  <= PW'(dax_s1) * PW'(wex_s1);
			t2_s2  <= PW'(day_s1) * PW'(wey_s1);
			dax_s2 <= dax_s1;
			day_s2 <= day_s1;
			dbx_s2 <= dbx_s1;
			dby_s2 <= dby_s1;
			asx_s2 <= asx_s1;
			asy_s2 <= asy_s1;
			aex_s2 <= aex_s1;
			aey_s2 <= aey_s1;
			bsx_s2 <= bsx_s1;
			bsy_s2 <= bsy_s1;

			a_s3   <= SW'(aa1_s2) + SW'(aa2_s2);
			e_s3   <= SW'(ee1_s2) + SW'(ee2_s2);
			cr_s3  <= SW'(c1_s2) - SW'(c2_s2);
			cbr_s3 <= SW'(k1_s2) - SW'(k2_s2);
			dbr_s3 <= SW'(m1_s2) + SW'(m2_s2);
			nas_s3 <= SW'(s1_s2) + SW'(s2_s2);
			nae_s3 <= SW'(t1_s2) + SW'(t2_s2);
			dax_s3 <= dax_s2;
			day_s3 <= day_s2;
			dbx_s3 <= dbx_s2;
			dby_s3 <= dby_s2;
			asx_s3 <= asx_s2;
			asy_s3 <= asy_s2;
			aex_s3 <= aex_s2;
			aey_s3 <= aey_s2;
			bsx_s3 <= bsx_s2;
			bsy_s3 <= bsy_s2;
		end
	end

	assign pa = (a_s3 <= SW'($signed({1'b0, thr_q})));
	assign pe = (e_s3 <= SW'($signed({1'b0, thr_q})));

	ssc_div #(.W(SW), .PF(PF)) u_div_cross (
		.clk(clk), .en(en), .num(cbr_s3), .den(cr_s3), .quo(sa0));
	ssc_div #(.W(SW), .PF(PF)) u_div_bs (
		.clk(clk), .en(en), .num(nas_s3), .den(a_s3), .quo(qs));
	ssc_div #(.W(SW), .PF(PF)) u_div_be (
		.clk(clk), .en(en), .num(nae_s3), .den(a_s3), .quo(qe));
	ssc_div #(.W(SW), .PF(PF)) u_div_ab (
		.clk(clk), .en(en), .num(dbr_s3), .den(e_s3), .quo(sbd));

	ssc_dly #(.W(2*CW+2*DW), .D(LD)) u_dly_l0 (
		.clk(clk), .en(en),
		.d({aex_s3, aey_s3, dax_s3, day_s3}),
		.q({aex_p, aey_p, dax_p, day_p}));
	ssc_dly #(.W(2*CW), .D(LD+2)) u_dly_bs (
		.clk(clk), .en(en), .d({bsx_s3, bsy_s3}), .q({bsx_p2, bsy_p2}));
	ssc_dly #(.W(2*DW), .D(LD+3)) u_dly_db (
		.clk(clk), .en(en), .d({dbx_s3, dby_s3}), .q({dbx_p3, dby_p3}));
	ssc_dly #(.W(SW), .D(LD+5)) u_dly_e (
		.clk(clk), .en(en), .d(e_s3), .q(e_p5));
	ssc_dly #(.W(4*DW+4*CW+2), .D(2*LD+5)) u_dly_x (
		.clk(clk), .en(en),
		.d({dax_s3, day_s3, dbx_s3, dby_s3, aex_s3, aey_s3, bsx_s3, bsy_s3, pa, pe}),
		.q({dax_x, day_x, dbx_x, dby_x, aex_x, aey_x, bsx_x, bsy_x, pa_x, pe_x}));
	ssc_dly #(.W(4*CW+1), .D(2*LD+7)) u_dly_x2 (
		.clk(clk), .en(en),
		.d({asx_s3, asy_s3, bsx_s3, bsy_s3, pa && pe}),
		.q({asx_x2, asy_x2, bsx_x2, bsy_x2, bp_x2}));
	ssc_dly #(.W(4*QW), .D(LD+5)) u_dly_q (
		.clk(clk), .en(en), .d({sa0, qs, qe, sbd}), .q({sa0_x, qs_x, qe_x, sbd_x}));

	// point on A from the crossing parameter, then project it onto B
	ssc_lerp #(.CW(CW), .PF(PF)) u_lerp_ax0 (
		.clk(clk), .en(en), .base(aex_p), .dir(dax_p), .s(sa0), .pt(pax0));
	ssc_lerp #(.CW(CW), .PF(PF)) u_lerp_ay0 (
		.clk(clk), .en(en), .base(aey_p), .dir(day_p), .s(sa0), .pt(pay0));

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s7  <= TW'(pax0) - TW'(bsx_p2);
			ty_s7  <= TW'(pay0) - TW'(bsy_p2);
			np1_s8 <= NPW'(dbx_p3) * NPW'(tx_s7);
			np2_s8 <= NPW'(dby_p3) * NPW'(ty_s7);
			n_s9   <= NW'(np1_s8) + NW'(np2_s8);
		end
	end

	ssc_div #(.W(NW), .PF(PF)) u_div_proj (
		.clk(clk), .en(en), .num(n_s9), .den(NW'(e_p5)), .quo(sbn));
	ssc_dly #(.W(2), .D(LD)) u_dly_flags (
		.clk(clk), .en(en),
		.d({n_s9 < 0, n_s9 > NW'(e_p5)}),
		.q({nneg_x, ngt_x}));

	// pick the parameters for the case at hand
	always_comb begin
		if (pa_x) begin
			sa_x = '0;
			sb_x = sbd_x;
		end else if (pe_x || nneg_x) begin
			sa_x = qs_x;
			sb_x = '0;
		end else if (ngt_x) begin
			sa_x = qe_x;
			sb_x = ONE;
		end else begin
			sa_x = sa0_x;
			sb_x = sbn;
		end
	end

	ssc_lerp #(.CW(CW), .PF(PF)) u_lerp_ax (
		.clk(clk), .en(en), .base(aex_x), .dir(dax_x), .s(sa_x), .pt(pax_l));
	ssc_lerp #(.CW(CW), .PF(PF)) u_lerp_ay (
		.clk(clk), .en(en), .base(aey_x), .dir(day_x), .s(sa_x), .pt(pay_l));
	ssc_lerp #(.CW(CW), .PF(PF)) u_lerp_bx (
		.clk(clk), .en(en), .base(bsx_x), .dir(dbx_x), .s(sb_x), .pt(pbx_l));
	ssc_lerp #(.CW(CW), .PF(PF)) u_lerp_by (
		.clk(clk), .en(en), .base(bsy_x), .dir(dby_x), .s(sb_x), .pt(pby_l));

	// both segments are points: report the two start points
	always_comb begin
		pax_m = bp_x2 ? DW'(asx_x2) : pax_l;
		pay_m = bp_x2 ? DW'(asy_x2) : pay_l;
		pbx_m = bp_x2 ? DW'(bsx_x2) : pbx_l;
		pby_m = bp_x2 ? DW'(bsy_x2) : pby_l;
	end

	assign gsum = XW'(sqx_s15) + XW'(sqy_s15);

	always_ff @(posedge clk) begin
		if (en) begin
			pax_s13 <= pax_m;
			pay_s13 <= pay_m;
			pbx_s13 <= pbx_m;
			pby_s13 <= pby_m;
			dx_s13  <= UW'(pax_m) - UW'(pbx_m);
			dy_s13  <= UW'(pay_m) - UW'(pby_m);

			pax_s14 <= pax_s13;
			pay_s14 <= pay_s13;
			pbx_s14 <= pbx_s13;
			pby_s14 <= pby_s13;
			ux_s14  <= dx_s13[UW-1] ? UW'(-dx_s13) : UW'(dx_s13);
			uy_s14  <= dy_s13[UW-1] ? UW'(-dy_s13) : UW'(dy_s13);

			pax_s15 <= pax_s14;
			pay_s15 <= pay_s14;
			pbx_s15 <= pbx_s14;
			pby_s15 <= pby_s14;
			sqx_s15 <= (2*UW)'(ux_s14) * (2*UW)'(ux_s14);
			sqy_s15 <= (2*UW)'(uy_s14) * (2*UW)'(uy_s14);

			pax_s16 <= pax_s15;
			pay_s16 <= pay_s15;
			pbx_s16 <= pbx_s15;
			pby_s16 <= pby_s15;
			gap_s16 <= (gsum > XW'(GMAX)) ? GMAX : gsum[GW-1:0];
		end
	end

	assign res.valid       = vld_q[STG_OUT];
	assign res.near_a_x    = pax_s16[CW-1:0];
	assign res.near_a_y    = pay_s16[CW-1:0];
	assign res.near_b_x    = pbx_s16[CW-1:0];
	assign res.near_b_y    = pby_s16[CW-1:0];
	assign res.gap_squared = gap_s16;

`include "segment_segment_closest_points_2d_assert.svh"

	`SSC_ASSERT_NEXT(a_accept_enters, seg.valid && seg.ready, vld_q[1], "accepted beat lost")
	`SSC_ASSERT_IMPL(a_param_range, vld_q[STG_X], sa_x <= ONE && sb_x <= ONE, "param above 1")
	`SSC_ASSERT_IMPL(a_zero_gap, res.valid && res.near_a_x == res.near_b_x && res.near_a_y == res.near_b_y, res.gap_squared == '0, "equal points with nonzero gap")
endmodule
`default_nettype wire

### rtl/ssc_dly.sv
// Enabled delay line for payload that rides alongside the long units.
`default_nettype none
module ssc_dly #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);
	logic [W-1:0] tap_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < D; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[D-1];
endmodule
`default_nettype wire

### rtl/ssc_div.sv
// Pipelined clamped divider: num/den limited to 0..1, one quotient bit per stage.
`default_nettype none
module ssc_div #(
	parameter int W  = 51,
	parameter int PF = 16
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic signed [W-1:0] num,
	input  wire logic signed [W-1:0] den,
	output logic             [PF:0]  quo
);
	localparam logic [PF:0] ONE = {1'b1, {PF{1'b0}}};

	logic signed [W:0] nn_s1;
	logic signed [W:0] dd_s1;
	logic              dz_s1;

	logic [W-1:0] rem_s [PF+2];
	logic [W-1:0] d_s   [PF+2];
	logic [PF:0]  q_s   [PF+2];
	logic         zr_s  [PF+2];
	logic         one_s [PF+2];

	logic [W:0]   r2 [PF+1];
	logic         ge [PF+1];
	logic [W-1:0] rn [PF+1];
	logic [PF+1:0] qr;
	logic [PF:0]  quo_q;

	// normalize the divisor to be positive
	always_ff @(posedge clk) begin
		if (en) begin
			if (den[W-1]) begin
				nn_s1 <= -((W+1)'(num));
				dd_s1 <= -((W+1)'(den));
			end else begin
				nn_s1 <= (W+1)'(num);
				dd_s1 <= (W+1)'(den);
			end
			dz_s1 <= (den == '0);
		end
	end

	always_comb begin
		for (int i = 0; i <= PF; i++) begin
			r2[i] = {rem_s[i], 1'b0};
			ge[i] = (r2[i] >= {1'b0, d_s[i]});
			rn[i] = ge[i] ? W'(r2[i] - {1'b0, d_s[i]}) : r2[i][W-1:0];
		end
	end

	assign qr = {1'b0, q_s[PF+1]} + (PF+2)'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			zr_s[0]  <= dz_s1 || (nn_s1 <= 0);
			one_s[0] <= (nn_s1 >= dd_s1);
			rem_s[0] <= nn_s1[W-1:0];
			d_s[0]   <= dd_s1[W-1:0];
			q_s[0]   <= '0;
			for (int i = 0; i <= PF; i++) begin
				rem_s[i+1] <= rn[i];
				d_s[i+1]   <= d_s[i];
				q_s[i+1]   <= {q_s[i][PF-1:0], ge[i]};
				zr_s[i+1]  <= zr_s[i];
				one_s[i+1] <= one_s[i];
			end
			// one extra bit, then round half up
			if (zr_s[PF+1]) begin
				quo_q <= '0;
			end else if (one_s[PF+1]) begin
				quo_q <= ONE;
			end else begin
				quo_q <= qr[PF+1:1];
			end
		end
	end

	assign quo = quo_q;
endmodule
`default_nettype wire

### rtl/ssc_lerp.sv
// Two-stage point former: base + round(dir * s), parameter in unsigned Q1.PF.
`default_nettype none
module ssc_lerp #(
	parameter int CW = 24,
	parameter int PF = 16
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic signed [CW-1:0] base,
	input  wire logic signed [CW:0]   dir,
	input  wire logic        [PF:0]   s,
	output logic signed      [CW:0]   pt
);
	localparam int DW = CW + 1;
	localparam int LW = DW + PF + 2;
	localparam logic signed [LW-1:0] HALF = LW'(2 ** (PF - 1));

	logic signed [LW-1:0] prod_s1;
	logic signed [CW-1:0] base_s1;
	logic signed [LW-1:0] w;
	logic signed [LW-1:0] sum;
	logic signed [DW-1:0] pt_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= LW'(dir) * $signed({1'b0, s});
			base_s1 <= base;
		end
	end

	always_comb begin
		w   = prod_s1 + HALF;
		sum = LW'(base_s1) + (w >>> PF);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s2 <= sum[DW-1:0];
		end
	end

	assign pt = pt_s2;
endmodule
`default_nettype wire
